// ----- sv/mvr_pkg.sv -----
// ----------------------------------------------------------------------------
// MAVLink v1 frame receiver package
// Parse phases, byte kind codes, framing constants and the X.25 CRC step.
// ----------------------------------------------------------------------------
package mvr_pkg;

    localparam logic [7:0]  START_BYTE   = 8'hFE;
    localparam logic [15:0] CRC_SEED     = 16'hFFFF;
    localparam logic [15:0] DROP_MAX     = 16'hFFFF;
    localparam int          OUT_DATA_W   = 72;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_LEN     = 4'd1,
        PH_SEQ     = 4'd2,
        PH_SYS     = 4'd3,
        PH_COMP    = 4'd4,
        PH_MSGID   = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CRCL    = 4'd7,
        PH_CRCH    = 4'd8
    } phase_t;

    typedef enum logic [3:0] {
        KIND_START     = 4'd0,
        KIND_LEN       = 4'd1,
        KIND_SEQ       = 4'd2,
        KIND_SYS       = 4'd3,
        KIND_COMP      = 4'd4,
        KIND_MSGID     = 4'd5,
        KIND_PAYLOAD   = 4'd6,
        KIND_CRC_LOW   = 4'd7,
        KIND_CRC_HIGH  = 4'd8
    } byte_kind_t;

    function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
               ^ {12'h000, t[7:4]};
    endfunction

endpackage

// ----- sv/mavlink_v1_frame_receiver.sv -----
// One received byte is taken per clock when the result register is free or being
// drained; parsing and the byte-wise X.25 CRC step are combinational, so the
// result appears in the cycle after the byte is accepted and the sustained rate
// is one byte per cycle. Bytes seen while waiting for the start byte are consumed
// and give no result. Every frame byte yields one result; the CRC high byte carries
// tlast, the computed and received CRC, the kept flag and the drop count.
// ----------------------------------------------------------------------------
// MAVLink v1 frame receiver
// Byte-stream parser for v1 frames with running X.25 CRC and drop counter.
// ----------------------------------------------------------------------------
module mavlink_v1_frame_receiver (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // rx_byte
    input  logic [0:0]                        s_axis_tuser,  // queue_full
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_byte[7:0], payload_index[15:8], computed_crc[31:16],
    // received_crc[47:32], frame_kept[48], drop_count[64:49], zero fill
    output logic [mvr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [3:0]                        m_axis_tuser,  // byte_kind
    output logic                              m_axis_tlast   // frame_last
);

    mvr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  payload_count_reg, payload_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [15:0] drop_reg, drop_next;

    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg;
    mvr_pkg::byte_kind_t kind_reg, kind_next;
    logic [7:0]  pidx_reg, pidx_next;
    logic        last_reg, last_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic        kept_reg, kept_next;

    logic        in_fire;
    logic        emit;
    logic [7:0]  b;
    logic        full;
    logic [15:0] crc_step;
    logic [7:0]  count_inc;

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign full          = s_axis_tuser[0];
    assign crc_step      = mvr_pkg::x25_update(crc_reg, b);
    assign count_inc     = payload_count_reg + 8'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        crc_next           = crc_reg;
        crc_low_next       = crc_low_reg;
        drop_next          = drop_reg;
        emit               = 1'b1;
        kind_next          = mvr_pkg::KIND_START;
        pidx_next          = 8'd0;
        last_next          = 1'b0;
        rcrc_next          = 16'd0;
        kept_next          = 1'b0;
        unique case (phase_reg)
            mvr_pkg::PH_LEN:
            begin
                kind_next         = mvr_pkg::KIND_LEN;
                frame_length_next = b;
                crc_next          = crc_step;
                phase_next        = mvr_pkg::PH_SEQ;
            end
            mvr_pkg::PH_SEQ:
            begin
                kind_next  = mvr_pkg::KIND_SEQ;
                crc_next   = crc_step;
                phase_next = mvr_pkg::PH_SYS;
            end
            mvr_pkg::PH_SYS:
            begin
                kind_next  = mvr_pkg::KIND_SYS;
                crc_next   = crc_step;
                phase_next = mvr_pkg::PH_COMP;
            end
            mvr_pkg::PH_COMP:
            begin
                kind_next  = mvr_pkg::KIND_COMP;
                crc_next   = crc_step;
                phase_next = mvr_pkg::PH_MSGID;
            end
            mvr_pkg::PH_MSGID:
            begin
                kind_next          = mvr_pkg::KIND_MSGID;
                crc_next           = crc_step;
                payload_count_next = 8'd0;
                phase_next         = (frame_length_reg == 8'd0) ? mvr_pkg::PH_CRCL
                                                                : mvr_pkg::PH_PAYLOAD;
            end
            mvr_pkg::PH_PAYLOAD:
            begin
                kind_next          = mvr_pkg::KIND_PAYLOAD;
                pidx_next          = payload_count_reg;
                crc_next           = crc_step;
                payload_count_next = count_inc;
                if (count_inc == frame_length_reg)
                begin
                    phase_next = mvr_pkg::PH_CRCL;
                end
            end
            mvr_pkg::PH_CRCL:
            begin
                kind_next    = mvr_pkg::KIND_CRC_LOW;
                crc_low_next = b;
                phase_next   = mvr_pkg::PH_CRCH;
            end
            mvr_pkg::PH_CRCH:
            begin
                kind_next  = mvr_pkg::KIND_CRC_HIGH;
                last_next  = 1'b1;
                rcrc_next  = {b, crc_low_reg};
                if (full)
                begin
                    if (drop_reg != mvr_pkg::DROP_MAX)
                    begin
                        drop_next = drop_reg + 16'd1;
                    end
                end
                else
                begin
                    kept_next = 1'b1;
                end
                phase_next = mvr_pkg::PH_IDLE;
            end
            default:
            begin
                if (b == mvr_pkg::START_BYTE)
                begin
                    crc_next           = mvr_pkg::CRC_SEED;
                    frame_length_next  = 8'd0;
                    payload_count_next = 8'd0;
                    crc_low_next       = 8'd0;
                    phase_next         = mvr_pkg::PH_LEN;
                end
                else
                begin
                    emit       = 1'b0;
                    phase_next = mvr_pkg::PH_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (in_fire)
        begin
            valid_next = emit;
        end
        else
        begin
            valid_next = valid_reg && !m_axis_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= mvr_pkg::PH_IDLE;
            frame_length_reg  <= 8'd0;
            payload_count_reg <= 8'd0;
            crc_reg           <= mvr_pkg::CRC_SEED;
            crc_low_reg       <= 8'd0;
            drop_reg          <= 16'd0;
            valid_reg         <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (in_fire)
            begin
                phase_reg         <= phase_next;
                frame_length_reg  <= frame_length_next;
                payload_count_reg <= payload_count_next;
                crc_reg           <= crc_next;
                crc_low_reg       <= crc_low_next;
                drop_reg          <= drop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            byte_reg <= b;
            kind_reg <= kind_next;
            pidx_reg <= pidx_next;
            last_reg <= last_next;
            rcrc_reg <= rcrc_next;
            kept_reg <= kept_next;
        end
    end

    // The result register is loaded in the same edge as the state, so the
    // CRC and drop count shown are the values after this byte.
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {7'd0, drop_reg, kept_reg, rcrc_reg, crc_reg, pidx_reg, byte_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

`ifndef SYNTH
    a_last_is_crc_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == mvr_pkg::KIND_CRC_HIGH)))
        else $error("tlast does not match the CRC high byte kind");

    a_kept_only_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && kept_reg) |-> m_axis_tlast)
        else $error("frame kept flag outside the final byte");

    a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (drop_reg >= $past(drop_reg)))
        else $error("drop counter went down");

    a_payload_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mvr_pkg::PH_PAYLOAD) |-> (payload_count_reg < frame_length_reg))
        else $error("payload count reached frame length inside payload");
`endif

endmodule
